// ----- rtl/crp_pkg.sv -----
// Shared types and constants for the clock page replacement block.
package crp_pkg;

  localparam int unsigned PAGE_W  = 16;
  localparam int unsigned FIDX_W  = 8;

  // Contents of one frame slot in the ring.
  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] page;
    logic              use_bit;
  } frame_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic shift;    // every cell loads its neighbor's slot
    logic set_use;  // the matching cell sets its use bit
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SWEEP
  } state_e;

endpackage

// ----- rtl/crp_cell.sv -----
// One frame slot of the rotating ring with its own page comparator.
module crp_cell #(
  parameter int unsigned IW = 8,
  parameter logic [IW-1:0] ID_RST = '0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  crp_pkg::cell_ctrl_t         ctrl_i,
  input  logic [crp_pkg::PAGE_W-1:0]  page_i,
  input  crp_pkg::frame_t             nxt_i,
  input  logic [IW-1:0]               nxt_id_i,
  output crp_pkg::frame_t             frm_o,
  output logic [IW-1:0]               id_o,
  output logic                        match_o
);
  import crp_pkg::*;

  frame_t        frm_q;
  logic [IW-1:0] id_q;
  logic          match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frm_q   <= '0;
      id_q    <= ID_RST;
      match_q <= 1'b0;
    end else begin
      match_q <= frm_q.valid && (frm_q.page == page_i);
      if (ctrl_i.shift) begin
        frm_q <= nxt_i;
        id_q  <= nxt_id_i;
      end else if (ctrl_i.set_use && match_q) begin
        frm_q.use_bit <= 1'b1;
      end
    end
  end

  assign frm_o   = frm_q;
  assign id_o    = id_q;
  assign match_o = match_q;

endmodule

// ----- rtl/crp_find_tree.sv -----
// Registered radix-4 OR tree that reports the frame id of the matching cell.
module crp_find_tree #(
  parameter int unsigned FRAMES = 256,
  parameter int unsigned IW     = 8,
  parameter int unsigned LEVELS = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [FRAMES-1:0]          match_i,
  input  logic [FRAMES-1:0][IW-1:0]  id_i,
  output logic                       hit_o,
  output logic [IW-1:0]              id_o
);
  import crp_pkg::*;

  localparam int unsigned LEAVES = 4 ** LEVELS;

  // Level 0 is the masked leaf layer; levels 1..LEVELS are registered.
  logic          lvl_hit [LEVELS+1][LEAVES];
  logic [IW-1:0] lvl_id  [LEVELS+1][LEAVES];

  for (genvar n = 0; n < LEAVES; n++) begin : g_leaf
    if (n < FRAMES) begin : g_real
      assign lvl_hit[0][n] = match_i[n];
      assign lvl_id[0][n]  = match_i[n] ? id_i[n] : '0;
    end else begin : g_pad
      assign lvl_hit[0][n] = 1'b0;
      assign lvl_id[0][n]  = '0;
    end
  end

  for (genvar lv = 1; lv <= LEVELS; lv++) begin : g_lvl
    for (genvar n = 0; n < LEAVES; n++) begin : g_node
      if (n < (LEAVES >> (2 * lv))) begin : g_used
        always_ff @(posedge clk_i or negedge rst_ni) begin
          if (!rst_ni) begin
            lvl_hit[lv][n] <= 1'b0;
            lvl_id[lv][n]  <= '0;
          end else begin
            lvl_hit[lv][n] <= lvl_hit[lv-1][4*n]   | lvl_hit[lv-1][4*n+1] |
                              lvl_hit[lv-1][4*n+2] | lvl_hit[lv-1][4*n+3];
            // at most one leaf matches, so an OR of masked ids selects it
            lvl_id[lv][n]  <= lvl_id[lv-1][4*n]   | lvl_id[lv-1][4*n+1] |
                              lvl_id[lv-1][4*n+2] | lvl_id[lv-1][4*n+3];
          end
        end
      end else begin : g_unused
        assign lvl_hit[lv][n] = 1'b0;
        assign lvl_id[lv][n]  = '0;
      end
    end
  end

  assign hit_o = lvl_hit[LEVELS][0];
  assign id_o  = lvl_id[LEVELS][0];

endmodule

// ----- rtl/clock_page_replacement.sv -----
// Top level: clock (second-chance) page replacement over a rotating ring of frame cells.
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+---------------------------------------
//  request   | in        | start_i & !busy_o      | page_number_i
//  result    | out       | done_o (one cycle)     | hit_o, frame_index_o, evicted_o,
//            |           |                        | evicted_page_o
//
//  Lookup: the search runs through one compare stage in the cells and a
//  registered radix-4 tree of LEVELS = ceil(log4 FRAMES) stages. On a miss
//  the hand then sweeps, clearing each set use bit it passes, and replaces
//  the first frame whose use bit is clear. For a hit or a miss, done_o
//  pulses in the same cycle that busy_o drops.
//  Reset empties every frame and parks the hand at frame 0; no clearing pass.
//  The receiver cannot stall: each result transfer is a single-cycle strobe.
//  A new request may be taken in the same cycle that done_o is high.
//
// The clock hand is implicit: the ring rotates so that the frame under the
// hand always sits in cell 0. Each cell carries its frame id along with it.
module clock_page_replacement #(
  parameter int unsigned FRAMES = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [crp_pkg::PAGE_W-1:0]  page_number_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic                        hit_o,
  output logic [crp_pkg::FIDX_W-1:0]  frame_index_o,
  output logic                        evicted_o,
  output logic [crp_pkg::PAGE_W-1:0]  evicted_page_o
);
  import crp_pkg::*;

  localparam int unsigned IW     = $clog2(FRAMES);
  localparam int unsigned LEVELS = ($clog2(FRAMES) + 1) / 2;
  localparam int unsigned LAT    = LEVELS + 1;        // compare stage + tree
  localparam int unsigned CW     = $clog2(LAT + 1);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q;
  logic [PAGE_W-1:0] page_q;

  // result registers
  logic              done_q, done_d;
  logic              hit_q, hit_d;
  logic [FIDX_W-1:0] fidx_q, fidx_d;
  logic              ev_q, ev_d;
  logic [PAGE_W-1:0] evp_q, evp_d;

  // ---------------------------------------------------------------------------
  // Ring of cells
  // ---------------------------------------------------------------------------
  cell_ctrl_t                 ctrl;
  frame_t                     frm    [FRAMES];
  logic [FRAMES-1:0][IW-1:0]  id_arr;
  logic [FRAMES-1:0]          match;
  frame_t                     head_out;   // what cell 0 hands to the last cell

  for (genvar p = 0; p < FRAMES; p++) begin : g_cell
    frame_t        nxt;
    logic [IW-1:0] nxt_id;

    if (p == FRAMES - 1) begin : g_wrap
      assign nxt    = head_out;
      assign nxt_id = id_arr[0];
    end else begin : g_link
      assign nxt    = frm[p+1];
      assign nxt_id = id_arr[p+1];
    end

    crp_cell #(
      .IW     (IW),
      .ID_RST (IW'(p))
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .page_i   (page_q),
      .nxt_i    (nxt),
      .nxt_id_i (nxt_id),
      .frm_o    (frm[p]),
      .id_o     (id_arr[p]),
      .match_o  (match[p])
    );
  end

  logic          tree_hit;
  logic [IW-1:0] tree_id;

  crp_find_tree #(
    .FRAMES (FRAMES),
    .IW     (IW),
    .LEVELS (LEVELS)
  ) u_tree (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .match_i (match),
    .id_i    (id_arr),
    .hit_o   (tree_hit),
    .id_o    (tree_id)
  );

  // frame ids widened then cut to the 8-bit result field
  logic [IW+FIDX_W-1:0] tree_id_wide, head_id_wide;
  assign tree_id_wide = {{FIDX_W{1'b0}}, tree_id};
  assign head_id_wide = {{FIDX_W{1'b0}}, id_arr[0]};

  logic search_done;
  assign search_done = (cnt_q == CW'(LAT));

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_LOOK;
      end
      S_LOOK: begin
        if (search_done) state_d = tree_hit ? S_IDLE : S_SWEEP;
      end
      S_SWEEP: begin
        if (!frm[0].use_bit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs: cell commands and result values
  // ---------------------------------------------------------------------------
  always_comb begin
    ctrl          = '0;
    head_out      = frm[0];
    head_out.use_bit = 1'b0;   // second chance: hand clears the use bit
    done_d        = 1'b0;
    hit_d         = hit_q;
    fidx_d        = fidx_q;
    ev_d          = ev_q;
    evp_d         = evp_q;
    unique case (state_q)
      S_IDLE: ;
      S_LOOK: begin
        if (search_done && tree_hit) begin
          ctrl.set_use = 1'b1;
          done_d       = 1'b1;
          hit_d        = 1'b1;
          fidx_d       = tree_id_wide[FIDX_W-1:0];
          ev_d         = 1'b0;
          evp_d        = '0;
        end
      end
      S_SWEEP: begin
        ctrl.shift = 1'b1;
        if (!frm[0].use_bit) begin
          // victim under the hand: replace it and move the hand on
          head_out.valid   = 1'b1;
          head_out.page    = page_q;
          head_out.use_bit = 1'b1;
          done_d = 1'b1;
          hit_d  = 1'b0;
          fidx_d = head_id_wide[FIDX_W-1:0];
          ev_d   = frm[0].valid;
          evp_d  = frm[0].valid ? frm[0].page : '0;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (state_q == S_LOOK) cnt_q <= cnt_q + CW'(1);
      else                   cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) page_q <= page_number_i;
    hit_q  <= hit_d;
    fidx_q <= fidx_d;
    ev_q   <= ev_d;
    evp_q  <= evp_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign frame_index_o  = fidx_q;
  assign evicted_o      = ev_q;
  assign evicted_page_o = evp_q;

endmodule
